### rtl/bpc_pkg.sv
// Package: payload types, register indexes, reset values and shared helpers.
package bpc_pkg;

    typedef struct packed {
        logic        kind;
        logic [15:0] raw_value;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] temp_tenths;
        logic [31:0] pressure_pa;
        logic        div_error;
    } out_t;

    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 32;

    localparam logic [CFG_IDX_W-1:0] REG_AC1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC3     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AC4     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B1      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B2      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD   = 3'd7;

    localparam logic [15:0] RST_AC1     = 16'd408;
    localparam logic [15:0] RST_AC2     = 16'hFFB8;
    localparam logic [15:0] RST_AC3     = 16'hC7D1;
    localparam logic [15:0] RST_AC4     = 16'd32741;
    localparam logic [15:0] RST_B1      = 16'd6190;
    localparam logic [15:0] RST_B2      = 16'd4;
    localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
    localparam logic [31:0] RST_MC_MD   = 32'd3724086068;

    localparam logic [31:0] K_B6_OFS  = 32'd4000;
    localparam logic [31:0] K_B7_MUL  = 32'd50000;
    localparam logic [31:0] K_P_MUL1  = 32'd3038;
    localparam logic [31:0] K_P_MUL2  = 32'hFFFF_E343;
    localparam logic [31:0] K_P_OFS   = 32'd3791;
    localparam logic [31:0] K_X3_OFS  = 32'd32768;

    function automatic logic [31:0] sext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // signed divide by 2^k, truncating toward zero
    function automatic logic [31:0] sdiv_pow2(input logic [31:0] v, input logic [4:0] k);
        logic [31:0] bias;
        logic [31:0] sum;
        bias = v[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
        sum  = v + bias;
        return 32'($signed(sum) >>> k);
    endfunction

endpackage

### rtl/bpc_mul.sv
// Bit-serial 32x32 multiplier returning the low 32 bits of the product.
module bpc_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        busy,
    output logic [31:0] prod
);

    logic [31:0] acc_reg, acc_next;
    logic [31:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            a_next    = a;
            b_next    = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = {a_reg[30:0], 1'b0};
            b_next   = {1'b0, b_reg[31:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

### rtl/bpc_div.sv
// Radix-2 restoring unsigned 32/32 divider, one quotient bit per cycle.
module bpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [31:0] quo
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] q_reg, q_next;
    logic [31:0] d_reg, d_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] rem_sh;
    logic [32:0] trial;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg, q_reg[31]};
        trial     = rem_sh - {1'b0, d_reg};
        if (start)
        begin
            rem_next  = '0;
            q_next    = num;
            d_next    = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    assign busy = busy_reg;
    assign quo  = q_reg;

endmodule

### rtl/barometric_pressure_compensation_top.sv
// Top level: compensation sequencer, calibration registers and handshakes.
// Sequencing: temperature uses 1 multiply and 1 divide, pressure 10 multiplies
// and 1 divide, issued one at a time on the bit-serial units.
// Throughput: one transaction at a time; the next is taken once the sequencer is idle.
// Reset: clears control state, stored b5, temperature and pressure; coefficients
// return to their calibration defaults.
module barometric_pressure_compensation_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  bpc_pkg::in_t                       in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output bpc_pkg::out_t                      out_data,
    input  logic                               cfg_we,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::DATA_W-1:0]         cfg_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_OUT} state_t;

    state_t      state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic        kind_reg, kind_next;
    logic [15:0] raw_reg, raw_next;
    logic        err_reg, err_next;
    logic        neg_reg, neg_next;
    logic        dbl_reg, dbl_next;
    logic [31:0] x1_reg, x1_next;
    logic [31:0] sq_reg, sq_next;
    logic [31:0] b3_reg, b3_next;
    logic [31:0] b4_reg, b4_next;
    logic [31:0] p_reg, p_next;
    logic [31:0] b5_reg, b5_next;
    logic [15:0] temp_reg, temp_next;
    logic [31:0] pres_reg, pres_next;
    logic        out_valid_reg, out_valid_next;
    bpc_pkg::out_t out_reg, out_next;

    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, b1_reg, b2_reg;
    logic [31:0] ac56_reg, mcmd_reg;

    logic        mul_start, div_start, mul_busy, div_busy;
    logic [31:0] mul_a, mul_b, mul_p, div_n, div_d, div_q;

    bpc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_p)
    );

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .busy  (div_busy),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac1_reg  <= bpc_pkg::RST_AC1;
            ac2_reg  <= bpc_pkg::RST_AC2;
            ac3_reg  <= bpc_pkg::RST_AC3;
            ac4_reg  <= bpc_pkg::RST_AC4;
            b1_reg   <= bpc_pkg::RST_B1;
            b2_reg   <= bpc_pkg::RST_B2;
            ac56_reg <= bpc_pkg::RST_AC5_AC6;
            mcmd_reg <= bpc_pkg::RST_MC_MD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bpc_pkg::REG_AC1:     ac1_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC2:     ac2_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC3:     ac3_reg  <= cfg_data[15:0];
                bpc_pkg::REG_AC4:     ac4_reg  <= cfg_data[15:0];
                bpc_pkg::REG_B1:      b1_reg   <= cfg_data[15:0];
                bpc_pkg::REG_B2:      b2_reg   <= cfg_data[15:0];
                bpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_data;
                bpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic [31:0] b6;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] q;

        state_next     = state_reg;
        step_next      = step_reg;
        kind_next      = kind_reg;
        raw_next       = raw_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        dbl_next       = dbl_reg;
        x1_next        = x1_reg;
        sq_next        = sq_reg;
        b3_next        = b3_reg;
        b4_next        = b4_reg;
        p_next         = p_reg;
        b5_next        = b5_reg;
        temp_next      = temp_reg;
        pres_next      = pres_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mul_start      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_n          = '0;
        div_d          = '0;
        b6  = b5_reg - bpc_pkg::K_B6_OFS;
        t1  = '0;
        t2  = '0;
        t3  = '0;
        num = '0;
        den = '0;
        q   = dbl_reg ? {div_q[30:0], 1'b0} : div_q;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next  = in_data.kind;
                    raw_next   = in_data.raw_value;
                    err_next   = 1'b0;
                    step_next  = '0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_WAIT;
                step_next  = step_reg + 4'd1;
                if (!kind_reg)
                begin
                    case (step_reg)
                        4'd0:
                        begin
                            mul_start = 1'b1;
                            mul_a     = {16'd0, raw_reg} - {16'd0, ac56_reg[15:0]};
                            mul_b     = {16'd0, ac56_reg[31:16]};
                        end
                        4'd1:
                        begin
                            t1  = bpc_pkg::sdiv_pow2(mul_p, 5'd15);
                            den = t1 + bpc_pkg::sext16(mcmd_reg[15:0]);
                            num = bpc_pkg::sext16(mcmd_reg[31:16]) << 11;
                            x1_next  = t1;
                            neg_next = num[31] ^ den[31];
                            dbl_next = 1'b0;
                            if (den == 32'd0)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                div_start = 1'b1;
                                div_n     = num[31] ? -num : num;
                                div_d     = den[31] ? -den : den;
                            end
                        end
                        default:
                        begin
                            t2 = x1_reg + (neg_reg ? -q : q);
                            t3 = bpc_pkg::sdiv_pow2(t2 + 32'd8, 5'd4);
                            b5_next = t2;
                            if (!t3[31] && t3[30:15] != 16'd0)
                                temp_next = 16'h7FFF;
                            else if (t3[31] && t3[30:15] != 16'hFFFF)
                                temp_next = 16'h8000;
                            else
                                temp_next = t3[15:0];
                            state_next = ST_OUT;
                        end
                    endcase
                end
                else
                begin
                    case (step_reg)
                        4'd0:
                        begin
                            mul_start = 1'b1;
                            mul_a     = b6;
                            mul_b     = b6;
                        end
                        4'd1:
                        begin
                            t1 = bpc_pkg::sdiv_pow2(mul_p, 5'd12);
                            sq_next   = t1;
                            mul_start = 1'b1;
                            mul_a     = bpc_pkg::sext16(b2_reg);
                            mul_b     = t1;
                        end
                        4'd2:
                        begin
                            x1_next   = bpc_pkg::sdiv_pow2(mul_p, 5'd11);
                            mul_start = 1'b1;
                            mul_a     = bpc_pkg::sext16(ac2_reg);
                            mul_b     = b6;
                        end
                        4'd3:
                        begin
                            t1 = x1_reg + bpc_pkg::sdiv_pow2(mul_p, 5'd11);
                            t2 = (bpc_pkg::sext16(ac1_reg) << 2) + t1 + 32'd2;
                            b3_next   = bpc_pkg::sdiv_pow2(t2, 5'd2);
                            mul_start = 1'b1;
                            mul_a     = bpc_pkg::sext16(ac3_reg);
                            mul_b     = b6;
                        end
                        4'd4:
                        begin
                            x1_next   = bpc_pkg::sdiv_pow2(mul_p, 5'd13);
                            mul_start = 1'b1;
                            mul_a     = bpc_pkg::sext16(b1_reg);
                            mul_b     = sq_reg;
                        end
                        4'd5:
                        begin
                            t1 = x1_reg + bpc_pkg::sdiv_pow2(mul_p, 5'd16) + 32'd2;
                            t2 = bpc_pkg::sdiv_pow2(t1, 5'd2);
                            mul_start = 1'b1;
                            mul_a     = {16'd0, ac4_reg};
                            mul_b     = t2 + bpc_pkg::K_X3_OFS;
                        end
                        4'd6:
                        begin
                            t1 = {15'd0, mul_p[31:15]};
                            b4_next = t1;
                            if (t1 == 32'd0)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                mul_start = 1'b1;
                                mul_a     = {16'd0, raw_reg} - b3_reg;
                                mul_b     = bpc_pkg::K_B7_MUL;
                            end
                        end
                        4'd7:
                        begin
                            div_start = 1'b1;
                            div_d     = b4_reg;
                            dbl_next  = mul_p[31];
                            div_n     = mul_p[31] ? mul_p : {mul_p[30:0], 1'b0};
                        end
                        4'd8:
                        begin
                            p_next    = q;
                            t1        = bpc_pkg::sdiv_pow2(q, 5'd8);
                            mul_start = 1'b1;
                            mul_a     = t1;
                            mul_b     = t1;
                        end
                        4'd9:
                        begin
                            mul_start = 1'b1;
                            mul_a     = mul_p;
                            mul_b     = bpc_pkg::K_P_MUL1;
                        end
                        4'd10:
                        begin
                            x1_next   = bpc_pkg::sdiv_pow2(mul_p, 5'd16);
                            mul_start = 1'b1;
                            mul_a     = bpc_pkg::K_P_MUL2;
                            mul_b     = p_reg;
                        end
                        default:
                        begin
                            t1 = x1_reg + bpc_pkg::sdiv_pow2(mul_p, 5'd16) + bpc_pkg::K_P_OFS;
                            pres_next  = p_reg + bpc_pkg::sdiv_pow2(t1, 5'd4);
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (!mul_busy && !div_busy)
                    state_next = ST_ISSUE;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next       = 1'b1;
                    out_next.result_kind = kind_reg;
                    out_next.temp_tenths = temp_reg;
                    out_next.pressure_pa = pres_reg;
                    out_next.div_error   = err_reg;
                    state_next           = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            b5_reg        <= '0;
            temp_reg      <= '0;
            pres_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            b5_reg        <= b5_next;
            temp_reg      <= temp_next;
            pres_reg      <= pres_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        raw_reg  <= raw_next;
        err_reg  <= err_next;
        neg_reg  <= neg_next;
        dbl_reg  <= dbl_next;
        x1_reg   <= x1_next;
        sq_reg   <= sq_next;
        b3_reg   <= b3_next;
        b4_reg   <= b4_next;
        p_reg    <= p_next;
        out_reg  <= out_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_busy && div_busy))
        else $error("multiplier and divider busy together");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!mul_busy && !div_busy))
        else $error("arithmetic unit busy while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_ISSUE && step_reg == 4'd0))
        else $error("accepted transaction did not start the sequencer");

    a_wait_started: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE && state_next == ST_WAIT) |=> (mul_busy || div_busy))
        else $error("sequencer waits with no unit started");

endmodule

### tb/barometric_pressure_compensation_top_test.sv
// Testbench: compensation predictor, randomized transactions with stalls, result checking.
module barometric_pressure_compensation_top_test;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    bpc_pkg::in_t                  in_data;
    logic                          out_valid;
    logic                          out_stall;
    bpc_pkg::out_t                 out_data;
    logic                          cfg_we;
    logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bpc_pkg::DATA_W-1:0]    cfg_data;

    logic [31:0]   cal [0:7];
    logic [31:0]   b5_q;
    logic [15:0]   temp_q;
    logic [31:0]   pres_q;
    bpc_pkg::out_t pending_results[$];
    int            fails;
    bit            quiet;
    int            idle_cycles;

    barometric_pressure_compensation_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic bit compensate_temperature(input logic [31:0] ut);
        logic [31:0] ac5, ac6, mc, md, x1, x2, den, b5, t;
        ac5 = {16'd0, cal[bpc_pkg::REG_AC5_AC6][31:16]};
        ac6 = {16'd0, cal[bpc_pkg::REG_AC5_AC6][15:0]};
        mc  = bpc_pkg::sext16(cal[bpc_pkg::REG_MC_MD][31:16]);
        md  = bpc_pkg::sext16(cal[bpc_pkg::REG_MC_MD][15:0]);
        x1  = div_trunc((ut - ac6) * ac5, 32'd32768);
        den = x1 + md;
        if (den == 32'd0)
            return 1'b0;
        x2 = div_trunc(mc * 32'd2048, den);
        b5 = x1 + x2;
        t  = div_trunc(b5 + 32'd8, 32'd16);
        b5_q = b5;
        if ($signed(t) > 32767)
            temp_q = 16'h7FFF;
        else if ($signed(t) < -32768)
            temp_q = 16'h8000;
        else
            temp_q = t[15:0];
        return 1'b1;
    endfunction

    function automatic bit compensate_pressure(input logic [31:0] up);
        logic [31:0] ac1, ac2, ac3, ac4, b1, b2, b6, sq, x1, x2, x3, b3, b4, b7, p;
        ac1 = bpc_pkg::sext16(cal[bpc_pkg::REG_AC1][15:0]);
        ac2 = bpc_pkg::sext16(cal[bpc_pkg::REG_AC2][15:0]);
        ac3 = bpc_pkg::sext16(cal[bpc_pkg::REG_AC3][15:0]);
        ac4 = {16'd0, cal[bpc_pkg::REG_AC4][15:0]};
        b1  = bpc_pkg::sext16(cal[bpc_pkg::REG_B1][15:0]);
        b2  = bpc_pkg::sext16(cal[bpc_pkg::REG_B2][15:0]);
        b6  = b5_q - 32'd4000;
        sq  = div_trunc(b6 * b6, 32'd4096);
        x1  = div_trunc(b2 * sq, 32'd2048);
        x2  = div_trunc(ac2 * b6, 32'd2048);
        x3  = x1 + x2;
        b3  = div_trunc(ac1 * 32'd4 + x3 + 32'd2, 32'd4);
        x1  = div_trunc(ac3 * b6, 32'd8192);
        x2  = div_trunc(b1 * sq, 32'd65536);
        x3  = div_trunc(x1 + x2 + 32'd2, 32'd4);
        b4  = (ac4 * (x3 + 32'd32768)) >> 15;
        if (b4 == 32'd0)
            return 1'b0;
        b7 = (up - b3) * 32'd50000;
        if (b7 < 32'h8000_0000)
            p = (b7 * 32'd2) / b4;
        else
            p = (b7 / b4) * 32'd2;
        x1 = div_trunc(p, 32'd256);
        x1 = x1 * x1;
        x1 = div_trunc(x1 * 32'd3038, 32'd65536);
        x2 = div_trunc(32'hFFFF_E343 * p, 32'd65536);
        pres_q = p + div_trunc(x1 + x2 + 32'd3791, 32'd16);
        return 1'b1;
    endfunction

    function automatic bpc_pkg::out_t predict_reading(input bpc_pkg::in_t item);
        bpc_pkg::out_t r;
        bit            ok;
        ok = item.kind ? compensate_pressure({16'd0, item.raw_value})
                       : compensate_temperature({16'd0, item.raw_value});
        r.result_kind = item.kind;
        r.temp_tenths = temp_q;
        r.pressure_pa = pres_q;
        r.div_error   = !ok;
        return r;
    endfunction

    task automatic send_reading(input logic kind, input logic [15:0] raw);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        in_data.kind      <= kind;
        in_data.raw_value <= raw;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(predict_reading({kind, raw}));
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_cal(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cal[idx] = (idx == bpc_pkg::REG_AC5_AC6 || idx == bpc_pkg::REG_MC_MD) ?
                   value : {16'd0, value[15:0]};
    endtask

    task automatic restore_defaults;
        write_cal(bpc_pkg::REG_AC1, {16'd0, bpc_pkg::RST_AC1});
        write_cal(bpc_pkg::REG_AC2, {16'd0, bpc_pkg::RST_AC2});
        write_cal(bpc_pkg::REG_AC3, {16'd0, bpc_pkg::RST_AC3});
        write_cal(bpc_pkg::REG_AC4, {16'd0, bpc_pkg::RST_AC4});
        write_cal(bpc_pkg::REG_B1, {16'd0, bpc_pkg::RST_B1});
        write_cal(bpc_pkg::REG_B2, {16'd0, bpc_pkg::RST_B2});
        write_cal(bpc_pkg::REG_AC5_AC6, bpc_pkg::RST_AC5_AC6);
        write_cal(bpc_pkg::REG_MC_MD, bpc_pkg::RST_MC_MD);
    endtask

    task automatic test_reset_defaults;
        send_reading(1'b1, 16'd23843);
        send_reading(1'b0, 16'd27898);
        send_reading(1'b1, 16'd23843);
        send_reading(1'b0, 16'h0000);
        send_reading(1'b1, 16'h0000);
        send_reading(1'b0, 16'hFFFF);
        send_reading(1'b1, 16'hFFFF);
        drain();
    endtask

    task automatic test_temp_div_zero;
        write_cal(bpc_pkg::REG_AC5_AC6, 32'h0000_1234);
        write_cal(bpc_pkg::REG_MC_MD, 32'h1000_0000);
        send_reading(1'b0, 16'd30000);
        send_reading(1'b1, 16'd20000);
        drain();
    endtask

    task automatic test_temp_saturation;
        write_cal(bpc_pkg::REG_MC_MD, 32'h7FFF_0001);
        send_reading(1'b0, 16'd100);
        send_reading(1'b1, 16'd40000);
        drain();
        write_cal(bpc_pkg::REG_MC_MD, 32'h8000_0001);
        send_reading(1'b0, 16'd100);
        send_reading(1'b1, 16'h8000);
        drain();
    endtask

    task automatic test_pressure_div_zero;
        write_cal(bpc_pkg::REG_AC4, 32'd0);
        send_reading(1'b1, 16'd25000);
        drain();
        write_cal(bpc_pkg::REG_AC4, 32'hFFFF);
        write_cal(bpc_pkg::REG_AC1, 32'h8000);
        write_cal(bpc_pkg::REG_AC2, 32'h7FFF);
        write_cal(bpc_pkg::REG_AC3, 32'hFFFF);
        write_cal(bpc_pkg::REG_B1, 32'h8000);
        write_cal(bpc_pkg::REG_B2, 32'h7FFF);
        write_cal(bpc_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
        write_cal(bpc_pkg::REG_MC_MD, 32'hFFFF_FFFF);
        send_reading(1'b0, 16'h0000);
        send_reading(1'b1, 16'hFFFF);
        send_reading(1'b0, 16'hFFFF);
        send_reading(1'b1, 16'h0001);
        drain();
    endtask

    task automatic test_random_sequences(input int phases, input int per_phase);
        int   i;
        int   r;
        logic [31:0] v;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph % 3 == 0)
                restore_defaults();
            else
                for (int k = 0; k < 8; k++)
                begin
                    r = $urandom_range(0, 5);
                    v = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF :
                        (r == 2) ? 32'h8000_8000 : (r == 3) ? 32'h7FFF_7FFF : $urandom;
                    write_cal(k[bpc_pkg::CFG_IDX_W-1:0], v);
                end
            if (ph == phases - 1)
                quiet = 1'b1;
            i = 0;
            while (i < per_phase)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    send_reading(1'b0, 16'($urandom_range(20000, 40000)));
                    send_reading(1'b1, 16'($urandom));
                    i += 2;
                end
                else
                begin
                    send_reading(1'($urandom_range(0, 1)), 16'($urandom));
                    i++;
                end
            end
            drain();
        end
    endtask

    always @(negedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (idle_cycles > 0)
        begin
            idle_cycles <= idle_cycles - 1;
            out_stall   <= 1'b1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            idle_cycles <= $urandom_range(0, 17);
            out_stall   <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        bpc_pkg::out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, out_data);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (want.result_kind !== out_data.result_kind)
                begin
                    $display("%0t result_kind exp %h act %h", $time,
                             want.result_kind, out_data.result_kind);
                    fails++;
                end
                if (want.temp_tenths !== out_data.temp_tenths)
                begin
                    $display("%0t temp_tenths exp %h act %h", $time,
                             want.temp_tenths, out_data.temp_tenths);
                    fails++;
                end
                if (want.pressure_pa !== out_data.pressure_pa)
                begin
                    $display("%0t pressure_pa exp %h act %h", $time,
                             want.pressure_pa, out_data.pressure_pa);
                    fails++;
                end
                if (want.div_error !== out_data.div_error)
                begin
                    $display("%0t div_error exp %h act %h", $time,
                             want.div_error, out_data.div_error);
                    fails++;
                end
            end
        end
    end

    int stuck_cycles;
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            stuck_cycles <= 0;
        else if (stuck_cycles >= 20000)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        fails        = 0;
        quiet        = 1'b0;
        idle_cycles  = 0;
        stuck_cycles = 0;
        cal[bpc_pkg::REG_AC1]     = {16'd0, bpc_pkg::RST_AC1};
        cal[bpc_pkg::REG_AC2]     = {16'd0, bpc_pkg::RST_AC2};
        cal[bpc_pkg::REG_AC3]     = {16'd0, bpc_pkg::RST_AC3};
        cal[bpc_pkg::REG_AC4]     = {16'd0, bpc_pkg::RST_AC4};
        cal[bpc_pkg::REG_B1]      = {16'd0, bpc_pkg::RST_B1};
        cal[bpc_pkg::REG_B2]      = {16'd0, bpc_pkg::RST_B2};
        cal[bpc_pkg::REG_AC5_AC6] = bpc_pkg::RST_AC5_AC6;
        cal[bpc_pkg::REG_MC_MD]   = bpc_pkg::RST_MC_MD;
        b5_q   = '0;
        temp_q = '0;
        pres_q = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_reset_defaults();
        test_temp_div_zero();
        test_temp_saturation();
        test_pressure_div_zero();
        test_random_sequences(12, 94);

        drain();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

### barometric_pressure_compensation_top.f
rtl/bpc_pkg.sv
rtl/bpc_mul.sv
rtl/bpc_div.sv
rtl/barometric_pressure_compensation_top.sv
tb/barometric_pressure_compensation_top_test.sv
